// ===== rtl/owp_pkg.sv =====
// Shared constants, types and small tables for the three-wheel odometry pose block.
// Used by the multiplier, divider, CORDIC and top-level sequencer files.
package owp_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int FRAC_BITS    = 16;

    localparam int TRV_SH  = 24 - FRAC_BITS;
    localparam int TURN_SH = 45 - FRAC_BITS;
    localparam int Q16_RSH = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
    localparam int Q16_LSH = (FRAC_BITS >= 16) ? 0 : (16 - FRAC_BITS);

    // divider: 32-bit magnitude followed by the Q29 scaling zeros
    localparam int DVD_W = 32 + TURN_SH;
    localparam int DCW   = $clog2(DVD_W + 1);
    localparam int CIW   = $clog2(CORDIC_STEPS + 1);

    localparam int MW = 33;
    localparam int PW = 2 * MW;

    typedef logic signed [MW-1:0] t_mop;
    typedef logic signed [PW-1:0] t_prod;

    localparam logic [30:0] PI_Q29           = 31'd1686629713;
    localparam logic [30:0] ONE_Q30          = 31'h4000_0000;
    localparam logic [31:0] FOUR_OVER_PI_Q30 = 32'd1367130551;
    localparam logic [31:0] CORDIC_GAIN_Q30  = 32'd652032874;
    localparam t_prod       RND30            = 66'sh2000_0000;

    localparam logic [2:0] SER_LAST = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_SIDE_IPC = 3'd0;
    localparam logic [2:0] CFG_BACK_IPC = 3'd1;
    localparam logic [2:0] CFG_LEFT_OFS = 3'd2;
    localparam logic [2:0] CFG_RIGHT_OFS = 3'd3;
    localparam logic [2:0] CFG_BACK_OFS = 3'd4;
    localparam logic [2:0] CFG_START_X  = 3'd5;
    localparam logic [2:0] CFG_START_Y  = 3'd6;
    localparam logic [2:0] CFG_START_H  = 3'd7;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Horner divisors of the sinc series, highest term first
    function automatic logic [6:0] ser_div(input logic [2:0] k);
        logic [6:0] d;
        case (k)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor); quotient lands low by at most one
    function automatic logic [29:0] ser_recip(input logic [2:0] k);
        logic [29:0] m;
        case (k)
            3'd0:    m = 30'd39045157;
            3'd1:    m = 30'd59652323;
            3'd2:    m = 30'd102261126;
            3'd3:    m = 30'd214748364;
            default: m = 30'd715827882;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] sat32(input t_prod v);
        logic fits;
        fits = (&v[PW-1:31]) || !(|v[PW-1:31]);
        if (fits) return v[31:0];
        return v[PW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic t_prod to_q16(input t_prod v);
        if (FRAC_BITS >= 16) return v >>> Q16_RSH;
        return v <<< Q16_LSH;
    endfunction

    function automatic t_mop sx33(input logic [31:0] v);
        return {v[31], v};
    endfunction

    function automatic t_mop ux33(input logic [31:0] v);
        return {1'b0, v};
    endfunction

endpackage

// ===== rtl/three_wheel_odometry_pose.sv =====
// Three tracking-wheel odometry. A sample transfer is worked through the steps below, and
// the block is ready again in the cycle the result appears. The steps, in order, are:
//   - travel scaling and divider start;
//   - a 61-step serial divider that forms the heading change;
//   - the five sinc series terms;
//   - a 24-step CORDIC that rotates the local offset;
//   - remaining products and result load.
// The scaling, series and rotation products all run one after another through a
// single shared 33x33 multiplier. A clear transfer goes straight to the final state,
// which loads the start pose as its result. One item is in work at a time, and
// the next one is accepted while the previous result waits to be taken. A finished
// item waits in its last state until the earlier result has been taken.
// Depends on owp_pkg, owp_mul, owp_div and owp_cordic.
module three_wheel_odometry_pose import owp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_right_count,
    input  logic signed [31:0] i_back_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic [31:0]        o_pose_heading,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_TRV_L, ST_TRV_R, ST_TRV_B, ST_DIV_GO, ST_DIV_WAIT,
        ST_SQ, ST_SQ_CAP, ST_SER_MUL, ST_SER_V, ST_SER_RM, ST_SER_Q0, ST_SER_FIX,
        ST_TWOS, ST_LX_A, ST_LX_B, ST_LX_C, ST_LY_A, ST_LY_B, ST_BAM,
        ST_ROT_GO, ST_ROT_WAIT, ST_PX_A, ST_PX_B, ST_PX_C, ST_PY_A, ST_PY_B, ST_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [31:0] r_side_ipc, r_back_ipc;
    logic [30:0] r_left_ofs, r_right_ofs;
    logic [31:0] r_back_ofs, r_start_x, r_start_y, r_start_h;

    // pose state
    logic [31:0] r_last_l, r_last_r, r_last_b;
    logic [31:0] r_acc_x, r_acc_y, r_acc_h;
    logic        r_out_valid;
    logic [31:0] r_out_x, r_out_y, r_out_h;
    logic [2:0]  r_k;

    // datapath
    logic [31:0] r_del_l, r_del_r, r_del_b;
    logic [31:0] r_dl, r_dr, r_db;
    logic        r_neg;
    logic [30:0] r_thmag;
    logic [31:0] r_th;
    logic [31:0] r_s, r_v, r_q0;
    logic [30:0] r_t;
    logic [31:0] r_twos, r_lx, r_ly;
    t_prod       r_acc;
    logic [32:0] r_thbam;

    logic        in_xfer;
    t_mop        mul_a, mul_b;
    t_prod       prod;
    logic        div_start, div_done;
    logic [30:0] div_quo;
    logic        rot_start, rot_done;
    t_mop        rot_cos, rot_sin;

    logic signed [32:0] dif;
    logic [31:0]        dif_mag;
    logic [31:0]        den;
    logic [6:0]         sdiv;
    logic [38:0]        q0d;
    logic [31:0]        rr;
    logic [31:0]        qfix;
    logic [30:0]        n_t;
    t_prod              lx_sum, ly_sum, bam_sum, px_sum, py_sum;
    logic [31:0]        n_mean;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    assign dif     = {r_dl[31], r_dl} - {r_dr[31], r_dr};
    assign dif_mag = dif[32] ? 32'(-dif) : dif[31:0];
    assign den     = {1'b0, r_left_ofs} + {1'b0, r_right_ofs};

    assign sdiv = ser_div(r_k);
    assign q0d  = 39'(r_q0) * 39'(sdiv);
    assign rr   = r_v - q0d[31:0];
    assign qfix = (rr >= {25'd0, sdiv}) ? (r_q0 + 32'd1) : r_q0;
    assign n_t  = ONE_Q30 - qfix[30:0];

    assign lx_sum  = r_acc + (prod >>> TURN_SH);
    assign ly_sum  = r_acc + (prod >>> TURN_SH);
    assign bam_sum = prod + RND30;
    assign px_sum  = r_acc + prod + RND30;
    assign py_sum  = r_acc - prod + RND30;
    assign n_mean  = r_acc_h + r_thbam[32:1];

    assign div_start = (r_state == ST_DIV_GO);
    assign rot_start = (r_state == ST_ROT_GO);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_TRV_L:   begin mul_a = sx33(r_del_l); mul_b = ux33(r_side_ipc); end
            ST_TRV_R:   begin mul_a = sx33(r_del_r); mul_b = ux33(r_side_ipc); end
            ST_TRV_B:   begin mul_a = sx33(r_del_b); mul_b = ux33(r_back_ipc); end
            ST_SQ:      begin mul_a = ux33({1'b0, r_thmag}); mul_b = ux33({1'b0, r_thmag}); end
            ST_SER_MUL: begin mul_a = ux33(r_s); mul_b = ux33({1'b0, r_t}); end
            ST_SER_RM:  begin mul_a = ux33(r_v); mul_b = ux33({2'b00, ser_recip(r_k)}); end
            ST_TWOS:    begin mul_a = sx33(r_th); mul_b = ux33({1'b0, r_t}); end
            ST_LX_A:    begin mul_a = sx33(r_db); mul_b = ux33({1'b0, r_t}); end
            ST_LX_B:    begin mul_a = sx33(r_twos); mul_b = sx33(r_back_ofs); end
            ST_LX_C:    begin mul_a = sx33(r_dr); mul_b = ux33({1'b0, r_t}); end
            ST_LY_A:    begin mul_a = sx33(r_twos); mul_b = ux33({1'b0, r_right_ofs}); end
            ST_LY_B:    begin mul_a = sx33(r_th); mul_b = ux33(FOUR_OVER_PI_Q30); end
            ST_PX_A:    begin mul_a = sx33(r_lx); mul_b = rot_cos; end
            ST_PX_B:    begin mul_a = sx33(r_ly); mul_b = rot_sin; end
            ST_PX_C:    begin mul_a = sx33(r_ly); mul_b = rot_cos; end
            ST_PY_A:    begin mul_a = sx33(r_lx); mul_b = rot_sin; end
            default:    begin mul_a = '0; mul_b = '0; end
        endcase
    end

    owp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    owp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (dif_mag),
        .i_den   (den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    owp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_angle (n_mean),
        .o_done  (rot_done),
        .o_cos   (rot_cos),
        .o_sin   (rot_sin)
    );

    // sequencer, configuration, pose state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_side_ipc  <= 32'd402653;
            r_back_ipc  <= 32'd402653;
            r_left_ofs  <= 31'd458752;
            r_right_ofs <= 31'd458752;
            r_back_ofs  <= 32'd458752;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_start_h   <= '0;
            r_last_l    <= '0;
            r_last_r    <= '0;
            r_last_b    <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_h     <= '0;
            r_k         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIDE_IPC:  r_side_ipc  <= i_cfg_data;
                    CFG_BACK_IPC:  r_back_ipc  <= i_cfg_data;
                    CFG_LEFT_OFS:  r_left_ofs  <= i_cfg_data[30:0];
                    CFG_RIGHT_OFS: r_right_ofs <= i_cfg_data[30:0];
                    CFG_BACK_OFS:  r_back_ofs  <= i_cfg_data;
                    CFG_START_X:   r_start_x   <= i_cfg_data;
                    CFG_START_Y:   r_start_y   <= i_cfg_data;
                    CFG_START_H:   r_start_h   <= i_cfg_data;
                    default:       r_start_h   <= r_start_h;
                endcase
            end

            // the final state loads its own result when the slot frees
            if (r_out_valid && i_out_ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_action) begin
                            r_acc_x  <= r_start_x;
                            r_acc_y  <= r_start_y;
                            r_acc_h  <= r_start_h;
                            r_last_l <= '0;
                            r_last_r <= '0;
                            r_last_b <= '0;
                            r_state  <= ST_FIN;
                        end else begin
                            r_last_l <= i_left_count;
                            r_last_r <= i_right_count;
                            r_last_b <= i_back_count;
                            r_state  <= ST_TRV_L;
                        end
                    end
                end
                ST_TRV_L:    r_state <= ST_TRV_R;
                ST_TRV_R:    r_state <= ST_TRV_B;
                ST_TRV_B:    r_state <= ST_DIV_GO;
                ST_DIV_GO:   r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: r_state <= ST_SQ_CAP;
                ST_SQ_CAP: begin
                    r_k     <= '0;
                    r_state <= ST_SER_MUL;
                end
                ST_SER_MUL: r_state <= ST_SER_V;
                ST_SER_V:   r_state <= ST_SER_RM;
                ST_SER_RM:  r_state <= ST_SER_Q0;
                ST_SER_Q0:  r_state <= ST_SER_FIX;
                ST_SER_FIX: begin
                    if (r_k == SER_LAST) begin
                        r_state <= ST_TWOS;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= ST_SER_MUL;
                    end
                end
                ST_TWOS:   r_state <= ST_LX_A;
                ST_LX_A:   r_state <= ST_LX_B;
                ST_LX_B:   r_state <= ST_LX_C;
                ST_LX_C:   r_state <= ST_LY_A;
                ST_LY_A:   r_state <= ST_LY_B;
                ST_LY_B:   r_state <= ST_BAM;
                ST_BAM:    r_state <= ST_ROT_GO;
                ST_ROT_GO: r_state <= ST_ROT_WAIT;
                ST_ROT_WAIT: begin
                    if (rot_done) begin
                        r_state <= ST_PX_A;
                    end
                end
                ST_PX_A: r_state <= ST_PX_B;
                ST_PX_B: r_state <= ST_PX_C;
                ST_PX_C: begin
                    r_acc_x <= r_acc_x + px_sum[61:30];
                    r_state <= ST_PY_A;
                end
                ST_PY_A: r_state <= ST_PY_B;
                ST_PY_B: begin
                    r_acc_y <= r_acc_y + py_sum[61:30];
                    r_acc_h <= r_acc_h + r_thbam[31:0];
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    // hold until the previous result has been taken
                    if (!r_out_valid || i_out_ready) begin
                        r_out_x     <= r_acc_x;
                        r_out_y     <= r_acc_y;
                        r_out_h     <= r_acc_h;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_del_l <= i_left_count - r_last_l;
                r_del_r <= i_right_count - r_last_r;
                r_del_b <= i_back_count - r_last_b;
            end
            ST_TRV_R:  r_dl <= sat32(prod >>> TRV_SH);
            ST_TRV_B:  r_dr <= sat32(prod >>> TRV_SH);
            ST_DIV_GO: begin
                r_db  <= sat32(prod >>> TRV_SH);
                r_neg <= dif[32];
            end
            ST_DIV_WAIT: begin
                r_thmag <= div_quo;
                r_th    <= r_neg ? -{1'b0, div_quo} : {1'b0, div_quo};
            end
            ST_SQ_CAP: begin
                r_s <= prod[61:30];
                r_t <= ONE_Q30;
            end
            ST_SER_V:   r_v  <= prod[61:30];
            ST_SER_Q0:  r_q0 <= prod[63:32];
            ST_SER_FIX: r_t  <= n_t;
            ST_LX_A:    r_twos <= prod[61:30];
            ST_LX_B:    r_acc  <= prod >>> 30;
            ST_LX_C:    r_lx   <= sat32(to_q16(lx_sum));
            ST_LY_A:    r_acc  <= prod >>> 30;
            ST_LY_B:    r_ly   <= sat32(to_q16(ly_sum));
            ST_BAM:     r_thbam <= bam_sum[62:30];
            ST_PX_B:    r_acc  <= prod;
            ST_PY_A:    r_acc  <= prod;
            default:    r_acc  <= r_acc;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_pose_x       = r_out_x;
    assign o_pose_y       = r_out_y;
    assign o_pose_heading = r_out_h;

`ifndef SYNTH
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_action) |=> (r_state == ST_TRV_L))
        else $error("sample transfer did not start the sequence");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_rot_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rot_done |-> (r_state == ST_ROT_WAIT))
        else $error("CORDIC finished outside its wait state");

    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> (r_thmag <= PI_Q29))
        else $error("heading change beyond pi");

    a_sinc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TWOS) |-> (r_t <= ONE_Q30))
        else $error("sinc series out of range");
`endif

endmodule

// ===== rtl/owp_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
// Depends on owp_pkg for operand and product types.
module owp_mul import owp_pkg::*; (
    input  logic  i_clk,
    input  t_mop  i_a,
    input  t_mop  i_b,
    output t_prod o_p
);

    t_prod r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/owp_div.sv =====
// Bit-serial restoring divider for the heading change in Q2.29 radians,
// saturated at pi. Depends on owp_pkg for widths and the pi constant.
module owp_div import owp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_mag,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [30:0] o_quo
);

    logic             r_busy;
    logic             r_done;
    logic [DCW-1:0]   r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [31:0]      r_rem;
    logic [31:0]      r_den;
    logic [32:0]      r_quo;
    logic             r_ovf;

    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;

    assign rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_mag, {TURN_SH{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
            // any quotient bit pushed past 33 bits means saturation
            r_ovf <= r_ovf | r_quo[32];
            r_quo <= {r_quo[31:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = (r_den == 32'd0) ? 31'd0 :
                    (r_ovf || (r_quo > {2'b00, PI_Q29})) ? PI_Q29 : r_quo[30:0];

endmodule

// ===== rtl/owp_cordic.sv =====
// Iterative rotation-mode CORDIC: cosine and sine of a binary angle in Q30.
// Depends on owp_pkg for the arctangent table, gain and step count.
module owp_cordic import owp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_angle,
    output logic        o_done,
    output t_mop        o_cos,
    output t_mop        o_sin
);

    logic               r_busy;
    logic               r_done;
    logic [CIW-1:0]     r_i;
    logic               r_flip;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;

    logic [31:0]        ang_q;
    logic [31:0]        ang_f;
    logic               flip;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;

    // fold the left half plane onto the right one
    assign ang_q = i_angle + 32'h4000_0000;
    assign flip  = ang_q[31];
    assign ang_f = flip ? (i_angle + 32'h8000_0000) : i_angle;

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign at = {2'b00, atan_bam(r_i[4:0])};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == CIW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= flip;
            r_x    <= {2'b00, CORDIC_GAIN_Q30};
            r_y    <= '0;
            r_z    <= {{2{ang_f[31]}}, ang_f};
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x[32:0] : r_x[32:0];
    assign o_sin  = r_flip ? -r_y[32:0] : r_y[32:0];

endmodule
